>>> design/spd_pkg.sv
package spd_pkg;

  localparam int unsigned NOW_W     = 32;
  localparam int unsigned ADC_W     = 10;
  localparam int unsigned PERIOD_W  = 10;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LED_INVERTED  = 3'd6;

  // detect modes; the unused code behaves as DC analog
  localparam logic [1:0] MODE_AC     = 2'd0;
  localparam logic [1:0] MODE_DC_DIG = 2'd1;

  // reset values
  localparam logic [1:0]          RST_DETECT_MODE   = MODE_AC;
  localparam logic                RST_ACTIVE_LEVEL  = 1'b1;
  localparam logic [ADC_W-1:0]    RST_ADC_THRESHOLD = 10'd572;
  localparam logic [PERIOD_W-1:0] RST_PERIOD_MIN    = 10'd18;
  localparam logic [PERIOD_W-1:0] RST_PERIOD_MAX    = 10'd22;
  localparam logic [HOLD_W-1:0]   RST_HOLD          = 16'd200;
  localparam logic                RST_LED_INVERTED  = 1'b0;

  typedef enum logic [2:0] {
    ST_OFF = 3'b001,
    ST_DEB = 3'b010,
    ST_ON  = 3'b100
  } pres_state_t;

  typedef struct packed {
    logic [1:0]          detect_mode;
    logic                active_level;
    logic [ADC_W-1:0]    adc_threshold;
    logic [PERIOD_W-1:0] period_min_ms;
    logic [PERIOD_W-1:0] period_max_ms;
    logic [HOLD_W-1:0]   hold_ms;
    logic                led_inverted;
  } spd_cfg_t;

  typedef struct packed {
    logic             led_enable;
    logic [NOW_W-1:0] now_ms;
    logic [ADC_W-1:0] adc_sample;
    logic             sense_level;
  } spd_item_t;

  typedef struct packed {
    logic led_level;
    logic present;
  } spd_result_t;

endpackage

>>> design/supply_presence_detector_top.sv
// Channel | Dir | Handshake             | Payload
// in_     | in  | in_tvalid / in_tready | in_tdata: sense_level, adc_sample, now_ms, led_enable
// out_    | out | out_tvalid/out_tready | out_tdata: present, led_level
// cfg_    | in  | cfg_we                | cfg_index, cfg_wdata
//
// One poll per cycle sustained while out_ does not stall.
// Poll register, then state update and result register in one pass.
// rst_n is synchronous: clears state, valids and config to defaults.
// A stall on out_ backs up into the poll register, then drops in_tready.
module supply_presence_detector_top
  import spd_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] sense_level, [10:1] adc_sample, [42:11] now_ms, [43] led_enable, rest zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] present, [1] led_level, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_wdata
);

  spd_cfg_t    cfg;
  spd_item_t   poll_r;
  logic        poll_valid_r;
  spd_result_t result, res_r;
  logic        res_valid_r;
  logic        fire;

  spd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign fire      = poll_valid_r && (!res_valid_r || out_tready);
  assign in_tready = !poll_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_valid_r <= 1'b0;
    end else if (in_tready) begin
      poll_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      poll_r <= spd_item_t'(in_tdata[$bits(spd_item_t)-1:0]);
    end
  end

  spd_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (poll_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (fire) begin
      res_valid_r <= 1'b1;
    end else if (out_tready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= result;
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-$bits(spd_result_t)){1'b0}}, res_r};

endmodule

>>> design/spd_cfg_regs.sv
module spd_cfg_regs
  import spd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output spd_cfg_t             cfg
);

  spd_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_mode   <= RST_DETECT_MODE;
      cfg_r.active_level  <= RST_ACTIVE_LEVEL;
      cfg_r.adc_threshold <= RST_ADC_THRESHOLD;
      cfg_r.period_min_ms <= RST_PERIOD_MIN;
      cfg_r.period_max_ms <= RST_PERIOD_MAX;
      cfg_r.hold_ms       <= RST_HOLD;
      cfg_r.led_inverted  <= RST_LED_INVERTED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DETECT_MODE:   cfg_r.detect_mode   <= cfg_wdata[1:0];
        REG_ACTIVE_LEVEL:  cfg_r.active_level  <= cfg_wdata[0];
        REG_ADC_THRESHOLD: cfg_r.adc_threshold <= cfg_wdata[ADC_W-1:0];
        REG_PERIOD_MIN:    cfg_r.period_min_ms <= cfg_wdata[PERIOD_W-1:0];
        REG_PERIOD_MAX:    cfg_r.period_max_ms <= cfg_wdata[PERIOD_W-1:0];
        REG_HOLD:          cfg_r.hold_ms       <= cfg_wdata[HOLD_W-1:0];
        REG_LED_INVERTED:  cfg_r.led_inverted  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/spd_core.sv
module spd_core
  import spd_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  spd_item_t   item,
  input  spd_cfg_t    cfg,
  output spd_result_t result
);

  logic                  prev_level_r, prev_level_nxt;
  logic [TIME_WIDTH-1:0] last_edge_r, last_edge_nxt;
  logic [TIME_WIDTH-1:0] first_edge_r, first_edge_nxt;
  pres_state_t           state_r, state_nxt;
  logic                  led_on_r, led_on_nxt;

  logic [TIME_WIDTH+NOW_W-1:0] now_ext;
  logic [TIME_WIDTH-1:0]       now_t;
  logic [TIME_WIDTH-1:0]       gap, since_last, since_first;
  logic                        reading, rise, valid, here;

  assign now_ext = {{TIME_WIDTH{1'b0}}, item.now_ms};
  assign now_t   = now_ext[TIME_WIDTH-1:0];

  assign reading = (item.sense_level == cfg.active_level);
  assign rise    = !prev_level_r && reading;
  assign gap     = now_t - last_edge_r;
  assign valid   = rise && (gap >= TIME_WIDTH'(cfg.period_min_ms))
                        && (gap <= TIME_WIDTH'(cfg.period_max_ms));

  assign here = (cfg.detect_mode == MODE_DC_DIG) ? reading
                                                 : (item.adc_sample >= cfg.adc_threshold);

  always_comb begin
    prev_level_nxt = prev_level_r;
    last_edge_nxt  = last_edge_r;
    first_edge_nxt = first_edge_r;
    state_nxt      = state_r;
    led_on_nxt     = led_on_r;
    since_last     = '0;
    since_first    = now_t - first_edge_r;
    if (cfg.detect_mode == MODE_AC) begin
      prev_level_nxt = reading;
      if (rise) begin
        last_edge_nxt = now_t;
      end
      // dropout uses the edge time as updated by this poll
      since_last = now_t - last_edge_nxt;
      unique case (state_r)
        ST_ON: begin
          if (item.led_enable) begin
            led_on_nxt = 1'b1;
          end
          if (since_last >= TIME_WIDTH'(cfg.hold_ms)) begin
            state_nxt = ST_OFF;
          end
        end
        ST_DEB: begin
          if (since_first >= TIME_WIDTH'(cfg.hold_ms)) begin
            state_nxt = ST_ON;
          end
        end
        default: begin
          if (item.led_enable) begin
            led_on_nxt = 1'b0;
          end
          if (valid) begin
            first_edge_nxt = now_t;
            state_nxt      = ST_DEB;
          end else begin
            state_nxt = state_r;
          end
        end
      endcase
    end else begin
      state_nxt  = here ? ST_ON : ST_OFF;
      led_on_nxt = item.led_enable && here;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      last_edge_r  <= '0;
      first_edge_r <= '0;
      state_r      <= ST_OFF;
      led_on_r     <= 1'b0;
    end else if (fire) begin
      prev_level_r <= prev_level_nxt;
      last_edge_r  <= last_edge_nxt;
      first_edge_r <= first_edge_nxt;
      state_r      <= state_nxt;
      led_on_r     <= led_on_nxt;
    end
  end

  assign result.present   = (state_nxt == ST_ON);
  assign result.led_level = led_on_nxt ^ cfg.led_inverted;

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(state_r) && $stable(led_on_r))
    else $error("presence state moved without a transfer");

  a_dc_keeps_edges: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cfg.detect_mode != MODE_AC |=>
      $stable(prev_level_r) && $stable(last_edge_r) && $stable(first_edge_r))
    else $error("DC poll touched edge tracking");

  a_on_not_deb: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cfg.detect_mode == MODE_AC && state_r == ST_ON |=>
      state_r == ST_ON || state_r == ST_OFF)
    else $error("on state went back to debounce");

  a_deb_needs_edge: assert property (@(posedge clk) disable iff (!rst_n)
    fire && state_r != ST_DEB && state_nxt == ST_DEB |-> valid)
    else $error("debounce entered without a valid edge");

endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spd_pkg::*;

  localparam logic [1:0] MODE_DC_ANA = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [0] sense_level, [10:1] adc_sample, [42:11] now_ms, [43] led_enable, rest zero
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] present, [1] led_level, rest zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DAT_W-1:0]  cfg_wdata = '0;

  supply_presence_detector_top dut (.*);

  // mirror of the block's registers and detector state
  spd_cfg_t    mcfg = '{RST_DETECT_MODE, RST_ACTIVE_LEVEL, RST_ADC_THRESHOLD,
                        RST_PERIOD_MIN, RST_PERIOD_MAX, RST_HOLD, RST_LED_INVERTED};
  logic        m_prev = 1'b0;
  logic [31:0] m_last_edge = '0;
  logic [31:0] m_first_edge = '0;
  pres_state_t m_state = ST_OFF;
  logic        m_led = 1'b0;

  spd_item_t   poll_q[$];
  spd_result_t verdict_q[$];
  spd_item_t   cur_poll;
  spd_result_t due;
  int          bad_count = 0;
  int          queued = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  logic [31:0] clock_ms = '0;

  initial forever #2 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic spd_result_t judge_poll(spd_item_t p);
    logic        reading;
    logic        edge_ok;
    logic        here;
    logic [31:0] gap;
    logic [31:0] span;
    spd_result_t r;
    if (mcfg.detect_mode == MODE_AC) begin
      reading = (p.sense_level == mcfg.active_level);
      edge_ok = 1'b0;
      if (!m_prev && reading) begin
        gap = p.now_ms - m_last_edge;
        m_last_edge = p.now_ms;
        edge_ok = (gap >= 32'(mcfg.period_min_ms)) && (gap <= 32'(mcfg.period_max_ms));
      end
      m_prev = reading;
      // LED is decided from the state held before this poll
      case (m_state)
        ST_ON: begin
          if (p.led_enable) m_led = 1'b1;
          span = p.now_ms - m_last_edge;
          if (span >= 32'(mcfg.hold_ms)) m_state = ST_OFF;
        end
        ST_DEB: begin
          span = p.now_ms - m_first_edge;
          if (span >= 32'(mcfg.hold_ms)) m_state = ST_ON;
        end
        default: begin
          if (p.led_enable) m_led = 1'b0;
          if (edge_ok) begin
            m_first_edge = p.now_ms;
            m_state = ST_DEB;
          end
        end
      endcase
    end else begin
      if (mcfg.detect_mode == MODE_DC_DIG) here = (p.sense_level == mcfg.active_level);
      else here = (p.adc_sample >= mcfg.adc_threshold);
      m_state = here ? ST_ON : ST_OFF;
      m_led = p.led_enable && here;
    end
    r.present = (m_state == ST_ON);
    r.led_level = m_led ^ mcfg.led_inverted;
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) verdict_q.push_back(judge_poll(cur_poll));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (poll_q.size() > 0) begin
        cur_poll = poll_q.pop_front();
        in_tdata <= IN_DATA_W'(cur_poll);
        in_tvalid <= 1'b1;
        if ($urandom_range(99) < in_idle_pct) in_gap <= $urandom_range(5, 1);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver and compare
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          bad_count++;
          $display("%0t: result with none expected, actual present=%0b led_level=%0b",
                   $time, out_tdata[0], out_tdata[1]);
        end else begin
          due = verdict_q.pop_front();
          if (out_tdata[0] !== due.present) begin
            bad_count++;
            $display("%0t: present expected %0b actual %0b", $time, due.present, out_tdata[0]);
          end
          if (out_tdata[1] !== due.led_level) begin
            bad_count++;
            $display("%0t: led_level expected %0b actual %0b",
                     $time, due.led_level, out_tdata[1]);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if ($urandom_range(99) < out_idle_pct) begin
        out_gap <= $urandom_range(4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // wait for the pipe to drain; sampled at negedge to stay clear of the clocked blocks
  task automatic settle();
    while (poll_q.size() != 0 || in_tvalid || verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DAT_W'(val);
    case (idx)
      REG_DETECT_MODE:   mcfg.detect_mode = val[1:0];
      REG_ACTIVE_LEVEL:  mcfg.active_level = val[0];
      REG_ADC_THRESHOLD: mcfg.adc_threshold = val[ADC_W-1:0];
      REG_PERIOD_MIN:    mcfg.period_min_ms = val[PERIOD_W-1:0];
      REG_PERIOD_MAX:    mcfg.period_max_ms = val[PERIOD_W-1:0];
      REG_HOLD:          mcfg.hold_ms = val[HOLD_W-1:0];
      REG_LED_INVERTED:  mcfg.led_inverted = val[0];
      default: ;
    endcase
  endtask

  task automatic write_regs(int mode, int act, int thr, int pmin, int pmax, int hold, int inv);
    settle();
    put_reg(REG_DETECT_MODE, mode);
    put_reg(REG_ACTIVE_LEVEL, act);
    put_reg(REG_ADC_THRESHOLD, thr);
    put_reg(REG_PERIOD_MIN, pmin);
    put_reg(REG_PERIOD_MAX, pmax);
    put_reg(REG_HOLD, hold);
    put_reg(REG_LED_INVERTED, inv);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void add_raw(bit lvl, int adc, logic [31:0] t, bit en);
    spd_item_t p;
    p.sense_level = lvl;
    p.adc_sample = ADC_W'(adc);
    p.now_ms = t;
    p.led_enable = en;
    poll_q.push_back(p);
    queued++;
  endfunction

  function automatic bit en_draw();
    return $urandom_range(9) != 0;
  endfunction

  function automatic void add_poll(bit hot, logic [31:0] t, bit en);
    add_raw(hot ? mcfg.active_level : ~mcfg.active_level, $urandom_range(1023), t, en);
  endfunction

  // mains-like waveform: low polls, a rising edge, a few high polls per period
  function automatic void mains_run(int edges);
    int lo, hi, gap, nl, nh;
    lo = mcfg.period_min_ms;
    hi = mcfg.period_max_ms;
    if (lo > hi) begin
      gap = lo;
      lo = hi;
      hi = gap;
    end
    for (int e = 0; e < edges; e++) begin
      if ($urandom_range(9) < 8) gap = $urandom_range(hi, lo);
      else gap = $urandom_range(hi + 20, 0);
      nl = $urandom_range(2, 1);
      for (int j = 0; j < nl; j++) add_poll(1'b0, clock_ms + gap / 2 + j, en_draw());
      clock_ms += gap;
      add_poll(1'b1, clock_ms, en_draw());
      nh = $urandom_range(2);
      for (int j = 0; j < nh; j++) add_poll(1'b1, clock_ms + j + 1, en_draw());
    end
  endfunction

  // pin stuck at one level while time runs on, so the hold time can run out
  function automatic void quiet_run(int n);
    bit hot;
    int stretch;
    hot = $urandom_range(1);
    stretch = mcfg.hold_ms / 8 + 2;
    for (int j = 0; j < n; j++) begin
      clock_ms += $urandom_range(stretch, 1);
      add_poll(hot, clock_ms, en_draw());
    end
  endfunction

  function automatic void noise_run(int n);
    for (int j = 0; j < n; j++)
      add_raw($urandom_range(1), $urandom_range(1023), $urandom, $urandom_range(1));
  endfunction

  function automatic void dc_run(int n);
    int a;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(1)) begin
        a = int'(mcfg.adc_threshold) + int'($urandom_range(4)) - 2;
        if (a < 0) a = 0;
        if (a > 1023) a = 1023;
      end else begin
        a = $urandom_range(1023);
      end
      clock_ms += $urandom_range(50);
      add_raw($urandom_range(1), a, clock_ms, en_draw());
    end
  endfunction

  task automatic run_phase(int items);
    int start;
    start = queued;
    while (queued - start < items) begin
      if (mcfg.detect_mode == MODE_AC) begin
        case ($urandom_range(9))
          6, 7: quiet_run($urandom_range(12, 3));
          8:    noise_run($urandom_range(4, 1));
          9: begin
            // broken waveform: a glitch lands between edges
            mains_run($urandom_range(4, 1));
            add_raw($urandom_range(1), $urandom_range(1023), clock_ms + $urandom_range(3),
                    en_draw());
          end
          default: mains_run($urandom_range(12, 2));
        endcase
      end else begin
        dc_run(8);
      end
    end
  endtask

  initial begin
    int mode, pmin, pmax, hold;
    while (!rst_n) @(negedge clk);
    in_idle_pct = 20;
    out_idle_pct = 20;

    // reset settings: AC, window 18..22, hold 200
    add_raw(1'b0, 0, 32'd0, 1'b1);
    add_raw(1'b1, 1023, 32'd5, 1'b1);      // edge too early
    add_raw(1'b0, 0, 32'd10, 1'b1);
    add_raw(1'b1, 0, 32'd23, 1'b1);        // gap at window low end, debounce starts
    add_raw(1'b0, 0, 32'd30, 1'b1);
    add_raw(1'b1, 0, 32'd45, 1'b1);        // gap at window high end
    add_raw(1'b0, 0, 32'd50, 1'b1);
    add_raw(1'b1, 0, 32'd62, 1'b1);        // gap just below window
    add_raw(1'b0, 0, 32'd100, 1'b1);
    add_raw(1'b1, 0, 32'd223, 1'b1);       // hold reached, turns on
    add_raw(1'b1, 0, 32'd224, 1'b1);       // on: LED driven on
    add_raw(1'b0, 0, 32'd424, 1'b0);       // dropout, LED kept
    add_raw(1'b0, 1023, 32'hFFFF_FFFF, 1'b1);
    write_regs(MODE_DC_DIG, 0, 572, 18, 22, 200, 1);
    add_raw(1'b0, 0, 32'd500, 1'b1);
    add_raw(1'b1, 0, 32'd501, 1'b1);
    add_raw(1'b0, 0, 32'd502, 1'b0);
    write_regs(MODE_DC_ANA, 1, 1023, 18, 22, 200, 0);
    add_raw(1'b1, 1022, 32'd600, 1'b1);
    add_raw(1'b0, 1023, 32'd601, 1'b1);
    write_regs(MODE_SPARE, 1, 0, 18, 22, 200, 0);   // unused mode acts as analog
    add_raw(1'b0, 0, 32'd700, 1'b1);
    add_raw(1'b1, 1023, 32'd701, 1'b0);
    write_regs(MODE_AC, 1, 572, 22, 18, 0, 0);      // inverted window: no edge valid
    add_raw(1'b0, 5, 32'd1000, 1'b1);
    add_raw(1'b1, 5, 32'd1020, 1'b1);
    add_raw(1'b0, 5, 32'd1030, 1'b1);
    add_raw(1'b1, 5, 32'd1040, 1'b1);

    // fixed settings, extremes among them
    write_regs(MODE_AC, 1, 572, 18, 22, 60, 0);
    run_phase(90);
    write_regs(MODE_AC, 0, 0, 0, 1000, 0, 1);
    run_phase(80);
    write_regs(MODE_AC, 1, 1023, 1000, 0, 40, 0);
    run_phase(60);
    write_regs(MODE_AC, 0, 500, 15, 25, 65535, 1);
    run_phase(80);
    clock_ms = 32'hFFFF_FF00;                        // timestamps wrap in this phase
    write_regs(MODE_AC, 1, 300, 20, 20, 100, 0);
    run_phase(90);
    write_regs(MODE_DC_DIG, 0, 100, 18, 22, 200, 1);
    run_phase(50);
    write_regs(MODE_DC_ANA, 1, 0, 18, 22, 200, 0);
    run_phase(40);
    write_regs(MODE_DC_ANA, 0, 1023, 18, 22, 200, 1);
    run_phase(40);
    write_regs(MODE_SPARE, 1, 512, 18, 22, 200, 0);
    run_phase(40);

    for (int k = 0; k < 7; k++) begin
      pmin = ($urandom_range(9) == 0) ? $urandom_range(1000) : $urandom_range(40, 2);
      pmax = pmin + $urandom_range(10);
      if ($urandom_range(7) == 0) pmax = pmin - $urandom_range(pmin);
      if (pmax > 1000) pmax = 1000;
      case ($urandom_range(9))
        0:       hold = 0;
        1:       hold = 65535;
        default: hold = $urandom_range(150, 10);
      endcase
      mode = ($urandom_range(9) < 6) ? MODE_AC : $urandom_range(3, 1);
      write_regs(mode, $urandom_range(1), $urandom_range(1023), pmin, pmax, hold,
                 $urandom_range(1));
      in_idle_pct = 10 * $urandom_range(3);
      out_idle_pct = 10 * $urandom_range(3);
      run_phase(60);
    end

    // closing stretch at full rate
    write_regs(MODE_AC, 1, 572, 18, 22, 50, 1);
    in_idle_pct = 0;
    out_idle_pct = 0;
    run_phase(80);

    settle();
    repeat (8) @(posedge clk);
    if (bad_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
